@@ design/rgpc_pkg.sv @@
// Package for the RGB gain block with ratio-preserving clamp.
// Holds payload structs, register indexes, depth codes and pipeline types.
// No dependencies.
package rgpc_pkg;

  localparam int PIX_W    = 8;
  localparam int GAIN_W   = 16;
  localparam int PROD_W   = PIX_W + GAIN_W;
  localparam int NUM_W    = 2 * PIX_W;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam int NUM_CH   = 3;

  localparam logic [GAIN_W-1:0]    GAIN_RESET = 16'd4096;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEPTH  = 1'd1;

  typedef enum logic [1:0] {
    DEPTH_24    = 2'd0,
    DEPTH_32    = 2'd1,
    DEPTH_UNSUP = 2'd2
  } depth_mode_e;

  typedef struct packed {
    logic [PIX_W-1:0] red_in;
    logic [PIX_W-1:0] green_in;
    logic [PIX_W-1:0] blue_in;
    logic [PIX_W-1:0] alpha_in;
    logic             last_in;
  } pix_in_t;

  typedef struct packed {
    logic [PIX_W-1:0] red_out;
    logic [PIX_W-1:0] green_out;
    logic [PIX_W-1:0] blue_out;
    logic [PIX_W-1:0] alpha_out;
    logic             last_out;
  } pix_out_t;

  // Classified item as it waits between front and back.
  typedef struct packed {
    logic [NUM_CH-1:0][PIX_W-1:0] chan;
    logic [PIX_W-1:0]             alpha;
    logic                         last;
    logic                         bypass;
  } q_entry_t;

  // After the gain multiply.
  typedef struct packed {
    logic [NUM_CH-1:0][PROD_W-1:0] prod;
    logic [NUM_CH-1:0][PIX_W-1:0]  raw;
    logic [PIX_W-1:0]              cmax;
    logic [PIX_W-1:0]              alpha;
    logic                          last;
    logic                          bypass;
  } mul_t;

  // Divider stage contents.
  typedef struct packed {
    logic [NUM_CH-1:0][NUM_W-1:0] rem;
    logic [NUM_CH-1:0][PIX_W-1:0] quo;
    logic [NUM_CH-1:0][PIX_W-1:0] direct;
    logic [PIX_W-1:0]             dvs;
    logic [PIX_W-1:0]             alpha;
    logic                         last;
    logic                         clamp;
  } div_t;

endpackage

@@ design/rgpc_front.sv @@
// Front end: holds the configuration registers and classifies incoming pixels.
// Depends on rgpc_pkg.
module rgpc_front import rgpc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  push_i,
  input  pix_in_t               pix_i,
  input  logic                  q_full_i,
  output logic                  q_wr_o,
  output q_entry_t              q_entry_o,
  output logic [GAIN_W-1:0]     gain_o
);

  logic [GAIN_W-1:0] gain_q;
  logic [1:0]        depth_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q  <= GAIN_RESET;
      depth_q <= DEPTH_24;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_GAIN:  gain_q  <= cfg_wdata_i[GAIN_W-1:0];
        CFG_DEPTH: depth_q <= cfg_wdata_i[1:0];
        default:   ;
      endcase
    end
  end

  always_comb begin
    q_entry_o.chan[0] = pix_i.red_in;
    q_entry_o.chan[1] = pix_i.green_in;
    q_entry_o.chan[2] = pix_i.blue_in;
    q_entry_o.last    = pix_i.last_in;
    q_entry_o.bypass  = !(depth_q == DEPTH_24 || depth_q == DEPTH_32);
    // 24-bit pixels carry no alpha
    q_entry_o.alpha   = (depth_q == DEPTH_24) ? '0 : pix_i.alpha_in;
  end

  assign q_wr_o = push_i && !q_full_i;
  assign gain_o = gain_q;

endmodule

@@ design/rgpc_fifo.sv @@
// Short first-word-fall-through queue between front and back.
// Depends on rgpc_pkg for the entry type.
module rgpc_fifo import rgpc_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     wr_i,
  input  q_entry_t wdata_i,
  input  logic     rd_i,
  output q_entry_t rdata_o,
  output logic     full_o,
  output logic     valid_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  q_entry_t           mem_q [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               do_rd;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign do_rd   = rd_i && valid_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (wr_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (wr_i && !do_rd) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!wr_i && do_rd) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

@@ design/rgpc_back.sv @@
// Back end: gain multiply, clamp decision and a one-bit-per-stage divider
// that rescales clamped pixels to floor(c * 255 / cmax). Depends on rgpc_pkg.
module rgpc_back import rgpc_pkg::*; #(
  parameter int GAIN_FRAC_BITS = 12
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [GAIN_W-1:0] gain_i,
  input  q_entry_t          q_entry_i,
  input  logic              q_valid_i,
  output logic              q_rd_o,
  input  logic              pop_i,
  output logic              empty_o,
  output pix_out_t          pix_o
);

  localparam int NSTG = PIX_W + 1;
  localparam logic [PROD_W-1:0] THRESH = PROD_W'(255) << GAIN_FRAC_BITS;

  logic            en;
  logic            s1_vld_q;
  mul_t            s1_q, s1_d;
  logic [NSTG-1:0] stg_vld_q;
  div_t            stg_q [NSTG];
  div_t            s2_d;
  logic [PROD_W-1:0] max_p;

  // Whole pipeline advances unless the finished item is held.
  assign en     = !stg_vld_q[NSTG-1] || pop_i;
  assign q_rd_o = en && q_valid_i;

  always_comb begin
    s1_d.raw    = q_entry_i.chan;
    s1_d.alpha  = q_entry_i.alpha;
    s1_d.last   = q_entry_i.last;
    s1_d.bypass = q_entry_i.bypass;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      s1_d.prod[ch] = PROD_W'(q_entry_i.chan[ch]) * PROD_W'(gain_i);
    end
    s1_d.cmax = (q_entry_i.chan[0] > q_entry_i.chan[1]) ? q_entry_i.chan[0]
                                                        : q_entry_i.chan[1];
    if (q_entry_i.chan[2] > s1_d.cmax) begin
      s1_d.cmax = q_entry_i.chan[2];
    end
  end

  // With equal gain on all channels, s * 255 / max(s) equals c * 255 / cmax.
  always_comb begin
    max_p = (s1_q.prod[0] > s1_q.prod[1]) ? s1_q.prod[0] : s1_q.prod[1];
    if (s1_q.prod[2] > max_p) begin
      max_p = s1_q.prod[2];
    end
    s2_d.clamp = !s1_q.bypass && (max_p > THRESH);
    s2_d.dvs   = s1_q.cmax;
    s2_d.alpha = s1_q.alpha;
    s2_d.last  = s1_q.last;
    s2_d.quo   = '0;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      s2_d.direct[ch] = s1_q.bypass ? s1_q.raw[ch]
                                    : PIX_W'(s1_q.prod[ch] >> GAIN_FRAC_BITS);
      s2_d.rem[ch]    = {s1_q.raw[ch], {PIX_W{1'b0}}} - NUM_W'(s1_q.raw[ch]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q     <= 1'b0;
      stg_vld_q[0] <= 1'b0;
    end else if (en) begin
      s1_vld_q     <= q_valid_i;
      stg_vld_q[0] <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_q     <= s1_d;
      stg_q[0] <= s2_d;
    end
  end

  // Restoring divide, one quotient bit per stage, MSB first.
  for (genvar j = 0; j < PIX_W; j++) begin : g_div
    logic [NUM_W-1:0] trial;
    div_t             nxt;

    assign trial = NUM_W'(stg_q[j].dvs) << (PIX_W - 1 - j);

    always_comb begin
      nxt = stg_q[j];
      for (int ch = 0; ch < NUM_CH; ch++) begin
        if (stg_q[j].rem[ch] >= trial) begin
          nxt.rem[ch]              = stg_q[j].rem[ch] - trial;
          nxt.quo[ch][PIX_W-1-j]   = 1'b1;
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        stg_vld_q[j+1] <= 1'b0;
      end else if (en) begin
        stg_vld_q[j+1] <= stg_vld_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        stg_q[j+1] <= nxt;
      end
    end
  end

  always_comb begin
    pix_o.red_out   = stg_q[NSTG-1].clamp ? stg_q[NSTG-1].quo[0] : stg_q[NSTG-1].direct[0];
    pix_o.green_out = stg_q[NSTG-1].clamp ? stg_q[NSTG-1].quo[1] : stg_q[NSTG-1].direct[1];
    pix_o.blue_out  = stg_q[NSTG-1].clamp ? stg_q[NSTG-1].quo[2] : stg_q[NSTG-1].direct[2];
    pix_o.alpha_out = stg_q[NSTG-1].alpha;
    pix_o.last_out  = stg_q[NSTG-1].last;
  end

  assign empty_o = !stg_vld_q[NSTG-1];

endmodule

@@ design/rgb_gain_ratio_preserving_clamp.sv @@
// Top level of the RGB gain block with ratio-preserving clamp.
// Instantiates rgpc_front, rgpc_fifo and rgpc_back; uses rgpc_pkg.
//
//   channel   ports                               accepted when
//   input     push, full, pix_i                   push && !full
//   result    pop, empty, pix_o                   pop && !empty
//   config    cfg_we_i, cfg_idx_i, cfg_wdata_i    cfg_we_i
//
// One pixel per clock in and out while results are popped and full is low.
// Stages: the gain multiply, the clamp decision and eight divider stages.
// Reset clears the queue and pipeline and sets gain to 1.0 and 24-bit depth.
// A held result stalls the back pipeline; the queue keeps taking pixels
// until its QUEUE_DEPTH entries are filled.
module rgb_gain_ratio_preserving_clamp import rgpc_pkg::*; #(
  parameter int GAIN_FRAC_BITS = 12,
  parameter int QUEUE_DEPTH    = 4
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  push,
  output logic                  full,
  input  pix_in_t               pix_i,
  input  logic                  pop,
  output logic                  empty,
  output pix_out_t              pix_o
);

  logic              q_wr, q_rd, q_full, q_valid;
  q_entry_t          q_wdata, q_rdata;
  logic [GAIN_W-1:0] gain;

  assign full = q_full;

  rgpc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .push_i      (push),
    .pix_i       (pix_i),
    .q_full_i    (q_full),
    .q_wr_o      (q_wr),
    .q_entry_o   (q_wdata),
    .gain_o      (gain)
  );

  rgpc_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (q_wr),
    .wdata_i (q_wdata),
    .rd_i    (q_rd),
    .rdata_o (q_rdata),
    .full_o  (q_full),
    .valid_o (q_valid)
  );

  rgpc_back #(
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .gain_i    (gain),
    .q_entry_i (q_rdata),
    .q_valid_i (q_valid),
    .q_rd_o    (q_rd),
    .pop_i     (pop),
    .empty_o   (empty),
    .pix_o     (pix_o)
  );

endmodule
